// ===== design/table_driven_dfa_recognizer_top_assert.svh =====
// Assertion macros for the table-driven DFA recognizer.
// Used by table_driven_dfa_recognizer_top; no other dependencies.
// Define ASSERT_OFF to compile the checks out.
`ifndef TABLE_DRIVEN_DFA_RECOGNIZER_TOP_ASSERT_SVH
`define TABLE_DRIVEN_DFA_RECOGNIZER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define DFAR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfar assertion failed");

// Next-cycle implication
`define DFAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfar assertion failed");

`else

`define DFAR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define DFAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/dfar_pkg.sv =====
// Shared types and constants for the table-driven DFA recognizer.
// No dependencies; imported by every module of the block.
package dfar_pkg;

    localparam int unsigned STATE_W     = 4;
    localparam int unsigned SYM_W       = 3;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned VERDICT_W   = 2;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned MASK_W      = 16;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Item kinds on the input stream
    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR  = 2'd0,
        KIND_EOS   = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    // Classified commands handed from front to back
    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_BAD   = 2'd1,
        OP_EOS   = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ACCEPT  = 2'd0,
        VERDICT_REJECT  = 2'd1,
        VERDICT_INVALID = 2'd2
    } verdict_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_INITIAL_STATE = 2'd0,
        REG_SYMBOL_COUNT  = 2'd1,
        REG_SYMBOL_LIST   = 2'd2,
        REG_ACCEPT_MASK   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        op_t                op;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] wr_state;
        logic [STATE_W-1:0] wr_next;
    } cmd_t;

endpackage

// ===== design/dfar_front.sv =====
// Front end: classifies each input item into a back-end command.
// Parallel symbol match for characters, range filter for table writes.
// Depends on dfar_pkg.
module dfar_front
    import dfar_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 8
)
(
    input  logic [KIND_W-1:0]     kind,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [STATE_W-1:0]    entry_state,
    input  logic [SYM_W-1:0]      entry_symbol,
    input  logic [STATE_W-1:0]    entry_next,
    input  logic [COUNT_W-1:0]    symbol_count,
    input  logic [CFG_DATA_W-1:0] symbol_list,
    output cmd_t                  cmd,
    output logic                  keep
);

    logic             hit_found;
    logic [SYM_W-1:0] hit_idx;

    // Compare against all active symbols; the highest matching index wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            if ((32'(i) < 32'(symbol_count)) && (symbol_list[8*i +: 8] == char_code))
            begin
                hit_found = 1'b1;
                hit_idx   = SYM_W'(i);
            end
        end
    end

    // Build the command; unused kinds and out-of-range writes are dropped
    always_comb
    begin
        cmd.op       = OP_EOS;
        cmd.sym      = hit_idx;
        cmd.wr_state = entry_state;
        cmd.wr_next  = entry_next;
        keep         = 1'b0;
        case (kind_t'(kind))
            KIND_CHAR:
            begin
                cmd.op = hit_found ? OP_STEP : OP_BAD;
                keep   = 1'b1;
            end
            KIND_EOS:
            begin
                cmd.op = OP_EOS;
                keep   = 1'b1;
            end
            KIND_WRITE:
            begin
                cmd.op  = OP_WRITE;
                cmd.sym = entry_symbol;
                keep    = (32'(entry_state) < NUM_STATES) &&
                          (32'(entry_symbol) < NUM_SYMBOLS);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/dfar_queue.sv =====
// Short command queue between the front and back ends.
// Depends on dfar_pkg for cmd_t and QUEUE_DEPTH.
module dfar_queue
    import dfar_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        count_next = CNT_W'(count_reg + CNT_W'(push) - CNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== design/dfar_back.sv =====
// Back end: automaton state, next-state register file and result register;
// executes one command per cycle, EOS held by a busy output. Uses dfar_pkg.
module dfar_back
    import dfar_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  cmd_t                 head,
    input  logic [STATE_W-1:0]   initial_state,
    input  logic [MASK_W-1:0]    accept_mask,
    input  logic                 m_tready,
    output logic                 pop,
    output logic                 m_tvalid,
    output logic [VERDICT_W-1:0] verdict,
    output logic [STATE_W-1:0]   final_state
);

    // Only states reachable through a 4-bit field get a row
    localparam int ROWS   = (NUM_STATES < (2 ** STATE_W)) ? NUM_STATES : (2 ** STATE_W);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SIDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    logic [NUM_SYMBOLS-1:0][STATE_W-1:0] table_reg [ROWS];

    logic [STATE_W-1:0] state_reg, state_next;
    logic               bad_reg, bad_next;
    logic               out_valid_reg, out_valid_next;
    verdict_t           verdict_reg, verdict_next;
    logic [STATE_W-1:0] final_reg, final_next;

    logic                                 out_free;
    logic                                 state_in_range;
    logic [NUM_SYMBOLS-1:0][STATE_W-1:0] cur_row;
    logic [STATE_W-1:0]                   step_state;
    verdict_t                             eos_verdict;

    assign out_free       = !out_valid_reg || m_tready;
    assign pop            = head_valid && ((head.op != OP_EOS) || out_free);
    assign state_in_range = (32'(state_reg) < NUM_STATES);
    assign cur_row        = table_reg[state_reg[ROW_W-1:0]];
    assign step_state     = cur_row[head.sym[SIDX_W-1:0]];

    // Verdict for the string ending now
    always_comb
    begin
        if (bad_reg)
        begin
            eos_verdict = VERDICT_INVALID;
        end
        else if (accept_mask[state_reg])
        begin
            eos_verdict = VERDICT_ACCEPT;
        end
        else
        begin
            eos_verdict = VERDICT_REJECT;
        end
    end

    // Command execution
    always_comb
    begin
        state_next     = state_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        verdict_next   = verdict_reg;
        final_next     = final_reg;
        if (pop)
        begin
            case (head.op)
                OP_STEP:
                begin
                    if (!bad_reg && state_in_range)
                    begin
                        state_next = step_state;
                    end
                end
                OP_BAD:
                begin
                    bad_next = 1'b1;
                end
                OP_EOS:
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = eos_verdict;
                    final_next     = state_reg;
                    state_next     = initial_state;
                    bad_next       = 1'b0;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        final_reg   <= final_next;
    end

    // Next-state register file; front end has already range-checked the write
    always_ff @(posedge clk)
    begin
        if (pop && (head.op == OP_WRITE))
        begin
            table_reg[head.wr_state[ROW_W-1:0]][head.sym[SIDX_W-1:0]] <= head.wr_next;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign verdict     = verdict_reg;
    assign final_state = final_reg;

endmodule

// ===== design/table_driven_dfa_recognizer_top.sv =====
// Programmable DFA recognizer: takes one item per cycle while the queue has room
// (character, end of string or next-state table write) and gives one verdict and final
// state per end of string. The front end matches a character against all symbols in
// parallel in the accept cycle; a two-entry command queue feeds the back end, which
// steps the state register through a register-file lookup once per cycle. Sustained rate
// is one item per clock; an end of string stalls only while the previous result is
// still held at the output. A result passes through the command queue and the result
// register after its end-of-string item is accepted. The table has no reset and must be
// written before a string uses it. Depends on dfar_pkg and the assertion header.
module table_driven_dfa_recognizer_top
    import dfar_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // char_code[7:0], entry_state[11:8], entry_symbol[14:12], entry_next[18:15], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // verdict[1:0], final_state[5:2], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

`include "table_driven_dfa_recognizer_top_assert.svh"

    logic [STATE_W-1:0]    initial_state_reg;
    logic [COUNT_W-1:0]    symbol_count_reg;
    logic [CFG_DATA_W-1:0] symbol_list_reg;
    logic [MASK_W-1:0]     accept_mask_reg;

    cmd_t                  front_cmd;
    logic                  front_keep;
    logic                  push;
    logic                  q_full;
    logic                  head_valid;
    cmd_t                  head;
    logic                  pop;
    logic [VERDICT_W-1:0]  verdict;
    logic [STATE_W-1:0]    final_state;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_state_reg <= '0;
            symbol_count_reg  <= COUNT_W'(1);
            symbol_list_reg   <= '0;
            accept_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_INITIAL_STATE: initial_state_reg <= cfg_data[STATE_W-1:0];
                REG_SYMBOL_COUNT:  symbol_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_SYMBOL_LIST:   symbol_list_reg   <= cfg_data;
                REG_ACCEPT_MASK:   accept_mask_reg   <= cfg_data[MASK_W-1:0];
                default:           symbol_list_reg   <= symbol_list_reg;
            endcase
        end
    end

    dfar_front #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_front (
        .kind         (s_tuser[KIND_W-1:0]),
        .char_code    (s_tdata[7:0]),
        .entry_state  (s_tdata[11:8]),
        .entry_symbol (s_tdata[14:12]),
        .entry_next   (s_tdata[18:15]),
        .symbol_count (symbol_count_reg),
        .symbol_list  (symbol_list_reg),
        .cmd          (front_cmd),
        .keep         (front_keep)
    );

    // Input is taken whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready && front_keep;

    dfar_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cmd_in     (front_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    dfar_back #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .initial_state (initial_state_reg),
        .accept_mask   (accept_mask_reg),
        .m_tready      (m_tready),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .verdict       (verdict),
        .final_state   (final_state)
    );

    assign m_tdata = {(OUT_TDATA_W - VERDICT_W - STATE_W)'(0), final_state, verdict};

    // Checks
    `DFAR_ASSERT_IMPLY(a_pop_needs_head, clk, rst_n, pop, head_valid)
    `DFAR_ASSERT_IMPLY(a_eos_waits_for_slot, clk, rst_n, pop && (head.op == OP_EOS),
                       !m_tvalid || m_tready)
    `DFAR_ASSERT_NEXT(a_eos_gives_result, clk, rst_n, pop && (head.op == OP_EOS), m_tvalid)

endmodule
